// ===== sv/adc_avg_pkg.sv =====
// Shared types, constants and digit helpers for the dual ADC averager.
// No dependencies; used by adc_avg_ctrl, adc_avg_dp and the top level.
package adc_avg_pkg;

  localparam int ADC_BITS  = 12;
  localparam int PCT_BITS  = 7;
  localparam int CHAR_W    = 6;
  // Step counter covers the longer of the two divide loops
  localparam int STEP_W    = $clog2(ADC_BITS);

  localparam logic [ADC_BITS-1:0] AVG_LIMIT = ADC_BITS'(999);
  localparam logic [PCT_BITS-1:0] PCT_MAX   = PCT_BITS'(99);
  localparam logic [PCT_BITS-1:0] PCT_SCALE = PCT_BITS'(100);

  localparam logic [CHAR_W-1:0] CHAR_SPACE = CHAR_W'(32);
  localparam logic [CHAR_W-1:0] CHAR_DASH  = CHAR_W'(45);
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);

  typedef struct packed {
    logic                func;
    logic [ADC_BITS-1:0] sample_a;
    logic [ADC_BITS-1:0] sample_b;
  } item_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] average_a;
    logic [ADC_BITS-1:0] average_b;
    logic [PCT_BITS-1:0] percent_diff;
    logic [CHAR_W-1:0]   char_0;
    logic [CHAR_W-1:0]   char_1;
    logic [CHAR_W-1:0]   char_2;
    logic [CHAR_W-1:0]   char_3;
    logic [CHAR_W-1:0]   char_4;
    logic [CHAR_W-1:0]   char_5;
    logic [CHAR_W-1:0]   char_6;
    logic [CHAR_W-1:0]   char_7;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_AVG,
    ST_PCT_LOAD,
    ST_DIV_PCT,
    ST_FMT_HUND,
    ST_FMT_TENS
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic acc;       // add sample pair
    logic div_load;  // latch sums into divider, clear accumulators
    logic avg_step;  // one quotient bit of both averages
    logic pct_load;  // latch averages, set up percent divide
    logic pct_step;  // one quotient bit of the percent divide
    logic fmt_hund;  // hundreds digits and clamp
    logic out_load;  // load result register
  } cmd_t;

  // v / 100 for v < 1000 via reciprocal 41/4096
  function automatic logic [3:0] hund_digit(input logic [9:0] v);
    logic [15:0] prod;
    prod = {6'b0, v} * 16'd41;
    return prod[15:12];
  endfunction

  // r / 10 for r < 128 via reciprocal 205/2048
  function automatic logic [3:0] tens_digit(input logic [6:0] r);
    logic [14:0] prod;
    prod = {8'b0, r} * 15'd205;
    return prod[14:11];
  endfunction

endpackage

// ===== sv/adc_avg_ctrl.sv =====
// Sequencer for the dual ADC averager: request handshake, divide loops, result valid.
// Depends on adc_avg_pkg.
module adc_avg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_func,
  output logic               item_ready,
  input  logic               result_ready,
  output logic               result_valid,
  output adc_avg_pkg::cmd_t  cmd
);
  import adc_avg_pkg::*;

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              result_valid_next;

  // State, step counter and result valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      step         <= step_next;
      result_valid <= result_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next        = state;
    step_next         = step;
    cmd               = '0;
    item_ready        = 1'b0;
    result_valid_next = result_valid && !result_ready;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if (item_func) begin
            cmd.div_load = 1'b1;
            step_next    = '0;
            state_next   = ST_DIV_AVG;
          end else begin
            cmd.acc = 1'b1;
          end
        end
      end
      ST_DIV_AVG: begin
        cmd.avg_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == STEP_W'(ADC_BITS - 1)) begin
          state_next = ST_PCT_LOAD;
        end
      end
      ST_PCT_LOAD: begin
        cmd.pct_load = 1'b1;
        step_next    = '0;
        state_next   = ST_DIV_PCT;
      end
      ST_DIV_PCT: begin
        cmd.pct_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == STEP_W'(PCT_BITS - 1)) begin
          state_next = ST_FMT_HUND;
        end
      end
      ST_FMT_HUND: begin
        cmd.fmt_hund = 1'b1;
        state_next   = ST_FMT_TENS;
      end
      ST_FMT_TENS: begin
        // wait for the result register to be free
        if (!result_valid || result_ready) begin
          cmd.out_load      = 1'b1;
          result_valid_next = 1'b1;
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/adc_avg_dp.sv =====
// Datapath of the dual ADC averager: accumulators, two restoring dividers,
// decimal formatting and the result register. Depends on adc_avg_pkg.
module adc_avg_dp #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  adc_avg_pkg::item_t    item,
  input  adc_avg_pkg::cmd_t     cmd,
  output adc_avg_pkg::result_t  result
);
  import adc_avg_pkg::*;

  localparam int SUM_W = ADC_BITS + COUNT_BITS;
  localparam int PN_W  = ADC_BITS + PCT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Accumulator state
  logic [SUM_W-1:0]      sum_a, sum_b;
  logic [COUNT_BITS-1:0] sample_count;

  // Average divider
  logic [COUNT_BITS-1:0] rem_a, rem_b, div_cnt;
  logic [ADC_BITS-1:0]   quo_a, quo_b;
  logic                  cnt_zero;

  // Percent divider
  logic [ADC_BITS-1:0]   avg_a, avg_b, prem, pdiv;
  logic [PCT_BITS-1:0]   plow, pct;
  logic                  big_zero;

  // Formatting
  logic                  over_a, over_b;
  logic [3:0]            hund_a, hund_b;
  logic [6:0]            rest_a, rest_b;

  // Step and load helpers
  logic [COUNT_BITS:0]   ta, tb, dext;
  logic                  ge_a, ge_b;
  logic [ADC_BITS:0]     tp, pext;
  logic                  ge_p;
  logic [ADC_BITS-1:0]   avg_a_v, avg_b_v, big, dif;
  logic [PN_W-1:0]       scaled;
  logic [3:0]            tens_a, tens_b, unit_a, unit_b, tens_p, unit_p;
  logic [6:0]            pct_ext;
  result_t               result_next;

  // Sums and count
  always_ff @(posedge clk) begin
    if (rst || cmd.div_load) begin
      sum_a        <= '0;
      sum_b        <= '0;
      sample_count <= '0;
    end else if (cmd.acc && sample_count != COUNT_MAX) begin
      sum_a        <= sum_a + SUM_W'(item.sample_a);
      sum_b        <= sum_b + SUM_W'(item.sample_b);
      sample_count <= sample_count + 1'b1;
    end
  end

  // One restoring step for each average
  always_comb begin
    dext = {1'b0, div_cnt};
    ta   = {rem_a, quo_a[ADC_BITS-1]};
    tb   = {rem_b, quo_b[ADC_BITS-1]};
    ge_a = ta >= dext;
    ge_b = tb >= dext;
  end

  // Quotient fits ADC_BITS, so the high part of the sum starts as remainder
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_a    <= sum_a[SUM_W-1:ADC_BITS];
      rem_b    <= sum_b[SUM_W-1:ADC_BITS];
      quo_a    <= sum_a[ADC_BITS-1:0];
      quo_b    <= sum_b[ADC_BITS-1:0];
      div_cnt  <= sample_count;
      cnt_zero <= (sample_count == '0);
    end else if (cmd.avg_step) begin
      rem_a <= ge_a ? COUNT_BITS'(ta - dext) : ta[COUNT_BITS-1:0];
      rem_b <= ge_b ? COUNT_BITS'(tb - dext) : tb[COUNT_BITS-1:0];
      quo_a <= {quo_a[ADC_BITS-2:0], ge_a};
      quo_b <= {quo_b[ADC_BITS-2:0], ge_b};
    end
  end

  // Averages, larger one and scaled difference
  always_comb begin
    avg_a_v = cnt_zero ? '0 : quo_a;
    avg_b_v = cnt_zero ? '0 : quo_b;
    if (avg_a_v > avg_b_v) begin
      big = avg_a_v;
      dif = avg_a_v - avg_b_v;
    end else begin
      big = avg_b_v;
      dif = avg_b_v - avg_a_v;
    end
    scaled = PN_W'(dif) * PN_W'(PCT_SCALE);
    pext   = {1'b0, pdiv};
    tp     = {prem, plow[PCT_BITS-1]};
    ge_p   = tp >= pext;
  end

  // Percent divide: quotient is at most 100, so PCT_BITS steps suffice
  always_ff @(posedge clk) begin
    if (cmd.pct_load) begin
      avg_a    <= avg_a_v;
      avg_b    <= avg_b_v;
      prem     <= scaled[PN_W-1:PCT_BITS];
      plow     <= scaled[PCT_BITS-1:0];
      pdiv     <= big;
      big_zero <= (big == '0);
    end else if (cmd.pct_step) begin
      prem <= ge_p ? ADC_BITS'(tp - pext) : tp[ADC_BITS-1:0];
      plow <= {plow[PCT_BITS-2:0], ge_p};
    end
  end

  // Hundreds digits and clamp
  always_ff @(posedge clk) begin
    if (cmd.fmt_hund) begin
      over_a <= avg_a > AVG_LIMIT;
      over_b <= avg_b > AVG_LIMIT;
      hund_a <= hund_digit(avg_a[9:0]);
      hund_b <= hund_digit(avg_b[9:0]);
      rest_a <= 7'(avg_a[9:0] - 10'({6'b0, hund_digit(avg_a[9:0])} * 10'd100));
      rest_b <= 7'(avg_b[9:0] - 10'({6'b0, hund_digit(avg_b[9:0])} * 10'd100));
      if (big_zero) begin
        pct <= '0;
      end else begin
        pct <= (plow > PCT_MAX) ? PCT_MAX : plow;
      end
    end
  end

  // Tens and units, character assembly
  always_comb begin
    pct_ext = 7'(pct);
    tens_a  = tens_digit(rest_a);
    tens_b  = tens_digit(rest_b);
    tens_p  = tens_digit(pct_ext);
    unit_a  = 4'(rest_a - 7'({3'b0, tens_a} * 7'd10));
    unit_b  = 4'(rest_b - 7'({3'b0, tens_b} * 7'd10));
    unit_p  = 4'(pct_ext - 7'({3'b0, tens_p} * 7'd10));

    result_next.average_a    = avg_a;
    result_next.average_b    = avg_b;
    result_next.percent_diff = pct;

    if (over_a) begin
      result_next.char_0 = CHAR_DASH;
      result_next.char_1 = CHAR_DASH;
      result_next.char_2 = CHAR_DASH;
    end else begin
      result_next.char_0 = (hund_a == '0) ? CHAR_SPACE : CHAR_ZERO + CHAR_W'(hund_a);
      result_next.char_1 = (hund_a == '0 && tens_a == '0) ? CHAR_SPACE
                                                         : CHAR_ZERO + CHAR_W'(tens_a);
      result_next.char_2 = CHAR_ZERO + CHAR_W'(unit_a);
    end

    if (over_b) begin
      result_next.char_3 = CHAR_DASH;
      result_next.char_4 = CHAR_DASH;
      result_next.char_5 = CHAR_DASH;
    end else begin
      result_next.char_3 = (hund_b == '0) ? CHAR_SPACE : CHAR_ZERO + CHAR_W'(hund_b);
      result_next.char_4 = (hund_b == '0 && tens_b == '0) ? CHAR_SPACE
                                                         : CHAR_ZERO + CHAR_W'(tens_b);
      result_next.char_5 = CHAR_ZERO + CHAR_W'(unit_b);
    end

    result_next.char_6 = (tens_p == '0) ? CHAR_SPACE : CHAR_ZERO + CHAR_W'(tens_p);
    result_next.char_7 = CHAR_ZERO + CHAR_W'(unit_p);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result <= result_next;
    end
  end

endmodule

// ===== sv/dual_adc_average_percent_display.sv =====
// Sample request: one per cycle while idle, no result.
// Update request: after acceptance run the 12 average divide steps, the percent
// load, the 7 percent divide steps and the two format states; the result loads
// when the result register is free, and the next request is taken the cycle after it loads.
// Reset (synchronous, active high) clears sums, count, state and result valid.
module dual_adc_average_percent_display #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  adc_avg_pkg::item_t    item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output adc_avg_pkg::result_t  result
);
  import adc_avg_pkg::*;

  cmd_t cmd;

  adc_avg_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_func    (item.func),
    .item_ready   (item_ready),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .cmd          (cmd)
  );

  adc_avg_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .result (result)
  );

  // An update request blocks further requests while it is worked on
  a_update_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.func |=> !item_ready)
    else $error("request taken during update");

  // Difference is clamped
  a_pct_clamp: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.percent_diff <= PCT_MAX)
    else $error("percent difference above clamp");

  // Overrange average A shows dashes
  a_dash: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.average_a > AVG_LIMIT |->
      result.char_0 == CHAR_DASH && result.char_2 == CHAR_DASH)
    else $error("overrange average not dashed");

endmodule
